// File: rtl/invcnt_pkg.sv
// ----------------------------------------------------------------------------
// Inversion counter package
// Shared constants and the control group that travels with each request
// along the row of comparison cells.
// ----------------------------------------------------------------------------
package invcnt_pkg;

   localparam int CAPACITY_DEFAULT     = 64;
   localparam int ELEMENT_BITS_DEFAULT = 16;

   localparam int                    COUNT_BITS = 11;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic valid;
      logic stored;
      logic last;
   } item_ctrl_type;

endpackage

// File: rtl/invcnt_cell.sv
// ----------------------------------------------------------------------------
// Inversion counter cell
// Holds one element of the current sequence. Each passing request is compared
// with it, claims it if it is empty, and clears it when it closes a sequence.
// ----------------------------------------------------------------------------
module invcnt_cell #(
   parameter int ELEMENT_BITS = invcnt_pkg::ELEMENT_BITS_DEFAULT,
   parameter int CNT_W        = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  invcnt_pkg::item_ctrl_type     in_ctrl,
   input  logic [ELEMENT_BITS-1:0]       in_element,
   input  logic [CNT_W-1:0]              in_count,
   output invcnt_pkg::item_ctrl_type     out_ctrl,
   output logic [ELEMENT_BITS-1:0]       out_element,
   output logic [CNT_W-1:0]              out_count
);

   logic                      held_valid_ff;
   logic                      held_valid_in;
   logic [ELEMENT_BITS-1:0]   held_ff;
   logic [ELEMENT_BITS-1:0]   held_in;
   invcnt_pkg::item_ctrl_type ctrl_ff;
   invcnt_pkg::item_ctrl_type ctrl_in;
   logic [ELEMENT_BITS-1:0]   element_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      hit;
   logic                      take;

   always_comb begin
      hit  = held_valid_ff && (held_ff > in_element);
      take = in_ctrl.valid && !held_valid_ff && !in_ctrl.stored;

      ctrl_in.valid  = in_ctrl.valid;
      ctrl_in.stored = in_ctrl.stored | take;
      ctrl_in.last   = in_ctrl.last;
      count_in       = in_count + {{(CNT_W-1){1'b0}}, hit};

      held_valid_in = held_valid_ff;
      if (in_ctrl.valid) begin
         if (in_ctrl.last) begin
            held_valid_in = 1'b0;
         end else if (take) begin
            held_valid_in = 1'b1;
         end
      end
      held_in = take ? in_element : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         ctrl_ff       <= '0;
      end else if (advance) begin
         held_valid_ff <= held_valid_in;
         ctrl_ff       <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff    <= held_in;
         element_ff <= in_element;
         count_ff   <= count_in;
      end
   end

   assign out_ctrl    = ctrl_ff;
   assign out_element = element_ff;
   assign out_count   = count_ff;

endmodule

// File: rtl/invcnt_accum.sv
// ----------------------------------------------------------------------------
// Inversion counter accumulator
// Adds each request's count of greater elements to the saturating running
// count, tracks overflow of the store and holds the response register.
// ----------------------------------------------------------------------------
module invcnt_accum #(
   parameter int CNT_W = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  invcnt_pkg::item_ctrl_type           in_ctrl,
   input  logic [CNT_W-1:0]                    in_count,
   output logic                                rsp_valid,
   output logic [invcnt_pkg::COUNT_BITS-1:0]   rsp_inversions,
   output logic                                rsp_sequence_done,
   output logic                                rsp_overflow
);

   localparam int SUM_W = invcnt_pkg::COUNT_BITS + 1;

   logic [invcnt_pkg::COUNT_BITS-1:0] running_ff;
   logic [invcnt_pkg::COUNT_BITS-1:0] running_in;
   logic                              ovf_seen_ff;
   logic                              ovf_seen_in;
   logic                              rsp_valid_ff;
   logic [invcnt_pkg::COUNT_BITS-1:0] inversions_ff;
   logic [invcnt_pkg::COUNT_BITS-1:0] inversions_in;
   logic                              done_ff;
   logic                              overflow_ff;
   logic                              overflow_in;
   logic [SUM_W-1:0]                  sum;
   logic                              take_item;

   always_comb begin
      take_item = advance && in_ctrl.valid;
      sum = {1'b0, running_ff} + SUM_W'(in_count);
      if (sum[SUM_W-1]) begin
         inversions_in = invcnt_pkg::COUNT_MAX;
      end else begin
         inversions_in = sum[invcnt_pkg::COUNT_BITS-1:0];
      end
      overflow_in = ovf_seen_ff | ~in_ctrl.stored;
      if (in_ctrl.last) begin
         running_in  = '0;
         ovf_seen_in = 1'b0;
      end else begin
         running_in  = inversions_in;
         ovf_seen_in = overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= in_ctrl.valid;
         end
         if (take_item) begin
            running_ff  <= running_in;
            ovf_seen_ff <= ovf_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         inversions_ff <= inversions_in;
         done_ff       <= in_ctrl.last;
         overflow_ff   <= overflow_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inversions    = inversions_ff;
   assign rsp_sequence_done = done_ff;
   assign rsp_overflow      = overflow_ff;

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (take_item && in_ctrl.last) |=> (running_ff == '0 && !ovf_seen_ff))
      else $error("Running state not cleared after the last request.");

   a_overflow_reported : assert property (@(posedge clock) disable iff (reset)
      (take_item && !in_ctrl.stored) |=> (rsp_valid && rsp_overflow))
      else $error("Unstored request not reported as overflow.");

   a_count_monotonic : assert property (@(posedge clock) disable iff (reset)
      (take_item && !in_ctrl.last) |=> (running_ff >= $past(running_ff)))
      else $error("Running count decreased within a sequence.");

   a_response_matches : assert property (@(posedge clock) disable iff (reset)
      (take_item && !in_ctrl.last) |=> (rsp_inversions == running_ff))
      else $error("Response count differs from running count.");

endmodule

// File: rtl/inversion_counter.sv
// ----------------------------------------------------------------------------
// Inversion counter
// Streaming count of the pairs in a sequence where an earlier element is
// strictly greater than a later one.
// ----------------------------------------------------------------------------
// Each request passes along a row of CAPACITY cells, one cell per cycle unless
// stalled. Every cell holds one earlier element of the sequence, counts the
// request if that element is greater, and the first empty cell keeps the new
// element. A new request is taken every cycle unless stalled, and its response
// comes out of the response register after the cell row; the whole row stalls
// while a response waits. A request marked final closes the sequence and
// empties each cell as it passes, so no clearing pass is needed after reset.
// Elements beyond CAPACITY are still counted but not kept, and raise the
// overflow flag until the sequence ends. The count saturates at 2047.
module inversion_counter #(
   parameter int CAPACITY     = invcnt_pkg::CAPACITY_DEFAULT,
   parameter int ELEMENT_BITS = invcnt_pkg::ELEMENT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ELEMENT_BITS-1:0]             req_element,
   input  logic                                req_final_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [invcnt_pkg::COUNT_BITS-1:0]   rsp_inversions,
   output logic                                rsp_sequence_done,
   output logic                                rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   invcnt_pkg::item_ctrl_type ctrl_w    [0:CAPACITY];
   logic [ELEMENT_BITS-1:0]   element_w [0:CAPACITY];
   logic [CNT_W-1:0]          count_w   [0:CAPACITY];
   logic                      advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign ctrl_w[0]    = '{valid: req_valid, stored: 1'b0, last: req_final_req};
   assign element_w[0] = req_element;
   assign count_w[0]   = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      invcnt_cell #(
         .ELEMENT_BITS (ELEMENT_BITS),
         .CNT_W        (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_ctrl     (ctrl_w[i]),
         .in_element  (element_w[i]),
         .in_count    (count_w[i]),
         .out_ctrl    (ctrl_w[i+1]),
         .out_element (element_w[i+1]),
         .out_count   (count_w[i+1])
      );
   end

   invcnt_accum #(
      .CNT_W (CNT_W)
   ) u_accum (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_ctrl           (ctrl_w[CAPACITY]),
      .in_count          (count_w[CAPACITY]),
      .rsp_valid         (rsp_valid),
      .rsp_inversions    (rsp_inversions),
      .rsp_sequence_done (rsp_sequence_done),
      .rsp_overflow      (rsp_overflow)
   );

endmodule
